### design/multi_reader_ring_buffer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-reader ring buffer
// ---------------------------------------------------------------------------
`ifndef MULTI_READER_RING_BUFFER_DEFINES_SVH
`define MULTI_READER_RING_BUFFER_DEFINES_SVH

// Clocked assertion, off while reset is high
`define MRRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define MRRB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mrrb_pkg.sv
// ---------------------------------------------------------------------------
// mrrb_pkg
// Shared constants, types and helpers of the multi-reader ring buffer.
// ---------------------------------------------------------------------------
package mrrb_pkg;

   localparam int DEPTH         = 16;
   localparam int CHANNELS      = 12;
   localparam int PAYLOAD_WIDTH = 32;

   localparam int IDX_W      = $clog2(DEPTH);
   localparam int MASK_W     = CHANNELS + 1;      // readers plus acquisition reader
   localparam int WORD_W     = 32;
   localparam int INTERVAL_W = 10;
   localparam int READER_W   = 4;
   localparam int TELEM_IDX_W = 4;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);

   // remainder unit: one dividend bit per cycle
   localparam int DIV_STEPS = WORD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   typedef logic [IDX_W-1:0]         index_type;
   typedef logic [MASK_W-1:0]        mask_type;
   typedef logic [PAYLOAD_WIDTH-1:0] payload_type;

   localparam mask_type ALL_MASK  = '1;
   localparam mask_type CHAN_MASK = ALL_MASK >> 1;

   typedef struct packed {
      logic                  req_type;
      logic [WORD_W-1:0]     payload;
      logic [WORD_W-1:0]     seq_number;
      logic [READER_W-1:0]   reader;
      logic                  acq_active;
   } req_item_type;

   typedef struct packed {
      logic                     granted;
      logic [WORD_W-1:0]        out_payload;
      logic [WORD_W-1:0]        out_seq;
      logic [WORD_W-1:0]        out_measure;
      logic                     dropped;
      logic                     telem_valid;
      logic [WORD_W-1:0]        telem_tick;
      logic [WORD_W-1:0]        telem_seq;
      logic [TELEM_IDX_W-1:0]   telem_head;
      logic [TELEM_IDX_W-1:0]   telem_tail;
      logic [WORD_W-1:0]        overflow_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic div_step;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
   } status_type;

   function automatic index_type ring_next(input index_type idx);
      return (idx == index_type'(DEPTH - 1)) ? '0 : idx + index_type'(1);
   endfunction

endpackage

### design/mrrb_req_if.sv
// ---------------------------------------------------------------------------
// mrrb_req_if
// Request channel: enqueue or dequeue items with valid/ready handshake.
// ---------------------------------------------------------------------------
interface mrrb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   req_type;
   logic [mrrb_pkg::WORD_W-1:0]            payload;
   logic [mrrb_pkg::WORD_W-1:0]            seq_number;
   logic [mrrb_pkg::READER_W-1:0]          reader;
   logic                                   acq_active;

   modport source (
      output valid, req_type, payload, seq_number, reader, acq_active,
      input  ready
   );

   modport sink (
      input  valid, req_type, payload, seq_number, reader, acq_active,
      output ready
   );
endinterface

### design/mrrb_rsp_if.sv
// ---------------------------------------------------------------------------
// mrrb_rsp_if
// Response channel: one result per request, valid/ready handshake.
// ---------------------------------------------------------------------------
interface mrrb_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   granted;
   logic [mrrb_pkg::WORD_W-1:0]            out_payload;
   logic [mrrb_pkg::WORD_W-1:0]            out_seq;
   logic [mrrb_pkg::WORD_W-1:0]            out_measure;
   logic                                   dropped;
   logic                                   telem_valid;
   logic [mrrb_pkg::WORD_W-1:0]            telem_tick;
   logic [mrrb_pkg::WORD_W-1:0]            telem_seq;
   logic [mrrb_pkg::TELEM_IDX_W-1:0]       telem_head;
   logic [mrrb_pkg::TELEM_IDX_W-1:0]       telem_tail;
   logic [mrrb_pkg::WORD_W-1:0]            overflow_count;

   modport source (
      output valid, granted, out_payload, out_seq, out_measure, dropped,
             telem_valid, telem_tick, telem_seq, telem_head, telem_tail,
             overflow_count,
      input  ready
   );

   modport sink (
      input  valid, granted, out_payload, out_seq, out_measure, dropped,
             telem_valid, telem_tick, telem_seq, telem_head, telem_tail,
             overflow_count,
      output ready
   );
endinterface

### design/mrrb_ctrl.sv
// ---------------------------------------------------------------------------
// mrrb_ctrl
// Sequencer: takes a request, runs the remainder steps if an enqueue needs them, commits the result.
// ---------------------------------------------------------------------------
module mrrb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mrrb_pkg::status_type   status,
   output mrrb_pkg::cmd_type      cmd
);

   localparam logic [mrrb_pkg::CNT_W-1:0] LAST_STEP = mrrb_pkg::CNT_W'(mrrb_pkg::DIV_STEPS - 1);

   mrrb_pkg::state_type            state_ff, state_in;
   logic [mrrb_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrrb_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         mrrb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = mrrb_pkg::ST_DIVIDE;
            end
         end
         mrrb_pkg::ST_DIVIDE: begin
            if (!status.need_div) begin
               state_in = mrrb_pkg::ST_COMMIT;
            end else begin
               cmd.div_step = 1'b1;
               if (cnt_ff == LAST_STEP) begin
                  cnt_in   = '0;
                  state_in = mrrb_pkg::ST_COMMIT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         mrrb_pkg::ST_COMMIT: begin
            // wait until the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mrrb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrrb_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/mrrb_dp.sv
// ---------------------------------------------------------------------------
// mrrb_dp
// Slot storage, ring pointers, counters, remainder unit and result register.
// ---------------------------------------------------------------------------
module mrrb_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [mrrb_pkg::INTERVAL_W-1:0]      csr_write_data,
   input  mrrb_pkg::req_item_type               req_data,
   input  mrrb_pkg::cmd_type                    cmd,
   output mrrb_pkg::status_type                 status,
   output mrrb_pkg::rsp_item_type               rsp_data
);

   logic [mrrb_pkg::INTERVAL_W-1:0]   interval_ff, interval_in;
   mrrb_pkg::req_item_type            item_ff;

   // remainder unit
   logic [mrrb_pkg::WORD_W-1:0]       dvd_ff, dvd_in;
   logic [mrrb_pkg::INTERVAL_W-1:0]   rem_ff, rem_in;
   logic [mrrb_pkg::INTERVAL_W:0]     rem_trial;

   // slot storage
   mrrb_pkg::payload_type             slot_payload_ff [mrrb_pkg::DEPTH];
   logic [mrrb_pkg::WORD_W-1:0]       slot_seq_ff     [mrrb_pkg::DEPTH];
   logic [mrrb_pkg::WORD_W-1:0]       slot_measure_ff [mrrb_pkg::DEPTH];
   mrrb_pkg::mask_type                slot_unread_ff  [mrrb_pkg::DEPTH];
   mrrb_pkg::mask_type                slot_read_ff    [mrrb_pkg::DEPTH];

   mrrb_pkg::index_type               head_ff, head_in, tail_ff, tail_in;
   logic [mrrb_pkg::WORD_W-1:0]       tick_ff, tick_in;
   logic [mrrb_pkg::WORD_W-1:0]       ovf_ff, ovf_in;
   logic [mrrb_pkg::WORD_W-1:0]       next_seq_ff, next_seq_in;
   mrrb_pkg::rsp_item_type            rsp_ff, rsp_in;

   // slot write controls
   logic                              data_wr;
   logic                              measure_wr;
   mrrb_pkg::index_type               measure_idx;
   logic [mrrb_pkg::WORD_W-1:0]       slot_measure_in;
   logic                              mask_wr;
   mrrb_pkg::index_type               mask_idx;
   mrrb_pkg::mask_type                slot_unread_in, slot_read_in;

   // commit helpers
   mrrb_pkg::index_type               head_next, tail_next;
   logic                              full, is_tick, grant, done;
   mrrb_pkg::mask_type                rd_bit, take, read_new, unread_new, need;
   logic [mrrb_pkg::WORD_W-1:0]       tail_measure, mark;

   assign status.need_div = (item_ff.req_type == mrrb_pkg::REQ_ENQUEUE) && (interval_ff != '0);

   // ---- remainder of seq_number by the interval, restoring, MSB first ----
   always_comb begin
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      rem_trial = {rem_ff, dvd_ff[mrrb_pkg::WORD_W-1]};
      if (cmd.capture) begin
         dvd_in = req_data.seq_number;
         rem_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         if (rem_trial >= {1'b0, interval_ff}) begin
            rem_in = mrrb_pkg::INTERVAL_W'(rem_trial - {1'b0, interval_ff});
         end else begin
            rem_in = rem_trial[mrrb_pkg::INTERVAL_W-1:0];
         end
      end
   end

   assign interval_in = csr_write_en ? csr_write_data : interval_ff;

   // ---- commit of one request ----
   always_comb begin
      head_next    = mrrb_pkg::ring_next(head_ff);
      tail_next    = mrrb_pkg::ring_next(tail_ff);
      full         = (head_next == tail_ff);
      is_tick      = status.need_div && (rem_ff == '0);
      mark         = tick_ff + 1'b1;
      tail_measure = slot_measure_ff[tail_ff];

      rd_bit = (32'(item_ff.reader) <= 32'(mrrb_pkg::CHANNELS))
               ? (mrrb_pkg::mask_type'(1) << item_ff.reader) : '0;
      grant      = |(slot_unread_ff[tail_ff] & rd_bit);
      take       = grant ? rd_bit : '0;
      read_new   = slot_read_ff[tail_ff] | take;
      unread_new = slot_unread_ff[tail_ff] & ~take;
      need       = item_ff.acq_active ? mrrb_pkg::ALL_MASK : mrrb_pkg::CHAN_MASK;
      done       = ((read_new & need) == need);

      head_in         = head_ff;
      tail_in         = tail_ff;
      tick_in         = tick_ff;
      ovf_in          = ovf_ff;
      next_seq_in     = next_seq_ff;
      rsp_in          = rsp_ff;
      data_wr         = 1'b0;
      measure_wr      = 1'b0;
      measure_idx     = head_ff;
      slot_measure_in = '0;
      mask_wr         = 1'b0;
      mask_idx        = head_ff;
      slot_unread_in  = '0;
      slot_read_in    = '0;

      if (cmd.commit) begin
         rsp_in = '0;
         if (item_ff.req_type == mrrb_pkg::REQ_ENQUEUE) begin
            if (full) begin
               ovf_in         = ovf_ff + 1'b1;
               rsp_in.dropped = 1'b1;
            end else begin
               data_wr         = 1'b1;
               measure_wr      = 1'b1;
               measure_idx     = head_ff;
               // a wrapped mark of zero reads as no measurement
               slot_measure_in = is_tick ? mark : '0;
               if (is_tick) begin
                  tick_in = mark;
               end
               mask_wr        = 1'b1;
               mask_idx       = head_ff;
               slot_unread_in = mrrb_pkg::ALL_MASK;
               slot_read_in   = '0;
               head_in        = head_next;
            end
            next_seq_in = item_ff.seq_number + 1'b1;
         end else begin
            if (grant) begin
               rsp_in.granted     = 1'b1;
               rsp_in.out_payload = mrrb_pkg::WORD_W'(slot_payload_ff[tail_ff]);
               rsp_in.out_seq     = slot_seq_ff[tail_ff];
               rsp_in.out_measure = tail_measure;
            end
            mask_wr  = 1'b1;
            mask_idx = tail_ff;
            if (done) begin
               slot_unread_in = '0;
               slot_read_in   = '0;
               if (tail_measure != '0) begin
                  rsp_in.telem_valid = 1'b1;
                  rsp_in.telem_tick  = tail_measure;
                  rsp_in.telem_seq   = next_seq_ff;
                  rsp_in.telem_head  = mrrb_pkg::TELEM_IDX_W'(head_ff);
                  rsp_in.telem_tail  = mrrb_pkg::TELEM_IDX_W'(tail_ff);
                  measure_wr         = 1'b1;
                  measure_idx        = tail_ff;
                  slot_measure_in    = '0;
               end
               // tail never steps onto the head slot
               if (tail_next != head_ff) begin
                  tail_in = tail_next;
               end
            end else begin
               slot_unread_in = unread_new;
               slot_read_in   = read_new;
            end
         end
         rsp_in.overflow_count = ovf_in;
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= mrrb_pkg::INTERVAL_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         tick_ff     <= '0;
         ovf_ff      <= '0;
         next_seq_ff <= '0;
         for (int i = 0; i < mrrb_pkg::DEPTH; i++) begin
            slot_unread_ff[i] <= '0;
            slot_read_ff[i]   <= '0;
         end
      end else begin
         interval_ff <= interval_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         tick_ff     <= tick_in;
         ovf_ff      <= ovf_in;
         next_seq_ff <= next_seq_in;
         if (mask_wr) begin
            slot_unread_ff[mask_idx] <= slot_unread_in;
            slot_read_ff[mask_idx]   <= slot_read_in;
         end
      end
   end

   // payload side: no reset, only read once the masks say the slot was written
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
      if (data_wr) begin
         slot_payload_ff[head_ff] <= mrrb_pkg::payload_type'(item_ff.payload);
         slot_seq_ff[head_ff]     <= item_ff.seq_number;
      end
      if (measure_wr) begin
         slot_measure_ff[measure_idx] <= slot_measure_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### design/multi_reader_ring_buffer.sv
// ---------------------------------------------------------------------------
// multi_reader_ring_buffer
// Broadcast ring of packet slots, taken once by each reader before it frees.
// ---------------------------------------------------------------------------
//  port      direction  handshake      carries
//  req_if    in         valid/ready    req_type, payload, seq_number, reader, acq_active
//  rsp_if    out        valid/ready    grant, slot data, drop flag, telemetry, overflows
//  csr_*     in         write enable   measure_interval (10 bits)
//
//  Enqueue with a nonzero interval: accept, 32 remainder steps of the
//  bit-serial modulo unit, commit. Dequeue, or interval zero: accept, divide state with no step, commit.
//  One request is in flight at a time; a new one is accepted while the last
//  result waits in the output register, and commit waits for that register.
//  Synchronous reset; no clearing pass, every slot mask is cleared by reset itself.
// ---------------------------------------------------------------------------
module multi_reader_ring_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [mrrb_pkg::INTERVAL_W-1:0]   csr_write_data,
   mrrb_req_if.sink                          req_if,
   mrrb_rsp_if.source                        rsp_if
);

   mrrb_pkg::cmd_type         cmd;
   mrrb_pkg::status_type      status;
   mrrb_pkg::req_item_type    req_data;
   mrrb_pkg::rsp_item_type    rsp_data;

   assign req_data.req_type   = req_if.req_type;
   assign req_data.payload    = req_if.payload;
   assign req_data.seq_number = req_if.seq_number;
   assign req_data.reader     = req_if.reader;
   assign req_data.acq_active = req_if.acq_active;

   mrrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrrb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_data       (rsp_data)
   );

   assign rsp_if.granted        = rsp_data.granted;
   assign rsp_if.out_payload    = rsp_data.out_payload;
   assign rsp_if.out_seq        = rsp_data.out_seq;
   assign rsp_if.out_measure    = rsp_data.out_measure;
   assign rsp_if.dropped        = rsp_data.dropped;
   assign rsp_if.telem_valid    = rsp_data.telem_valid;
   assign rsp_if.telem_tick     = rsp_data.telem_tick;
   assign rsp_if.telem_seq      = rsp_data.telem_seq;
   assign rsp_if.telem_head     = rsp_data.telem_head;
   assign rsp_if.telem_tail     = rsp_data.telem_tail;
   assign rsp_if.overflow_count = rsp_data.overflow_count;

endmodule

### design/mrrb_checker.sv
// ---------------------------------------------------------------------------
// mrrb_checker
// Port-level checks of the ring buffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "multi_reader_ring_buffer_defines.svh"

module mrrb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            granted,
   input logic [mrrb_pkg::WORD_W-1:0]     out_payload,
   input logic [mrrb_pkg::WORD_W-1:0]     out_seq,
   input logic [mrrb_pkg::WORD_W-1:0]     out_measure,
   input logic                            dropped,
   input logic                            telem_valid,
   input logic [mrrb_pkg::WORD_W-1:0]     overflow_count
);

   // stalled result holds
   `MRRB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted) && $stable(out_payload) && $stable(overflow_count), "result changed while stalled")

   // one request in flight: a transfer drops ready on the next cycle
   `MRRB_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // no grant means no slot data
   `MRRB_ASSERT(a_no_grant_zero, clock, reset, rsp_valid && !granted |-> out_payload == '0 && out_seq == '0 && out_measure == '0, "slot data without grant")

   // a drop comes from an enqueue, grants and telemetry from a dequeue
   `MRRB_ASSERT(a_drop_exclusive, clock, reset, rsp_valid && dropped |-> !granted && !telem_valid, "drop mixed with dequeue result")

   // reset leaves the block empty and ready
   `MRRB_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "bad state after reset")

endmodule

bind multi_reader_ring_buffer mrrb_checker u_mrrb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .granted        (rsp_if.granted),
   .out_payload    (rsp_if.out_payload),
   .out_seq        (rsp_if.out_seq),
   .out_measure    (rsp_if.out_measure),
   .dropped        (rsp_if.dropped),
   .telem_valid    (rsp_if.telem_valid),
   .overflow_count (rsp_if.overflow_count)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives random and directed enqueue/dequeue traffic into the broadcast ring
// and checks every response against a cycle-free model of the slot ring.
// ---------------------------------------------------------------------------
module tb;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [mrrb_pkg::INTERVAL_W-1:0] csr_write_data;

   mrrb_req_if req_ch ();
   mrrb_rsp_if rsp_ch ();

   multi_reader_ring_buffer u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch)
   );

   // ring model state
   mrrb_pkg::payload_type           slot_pay     [mrrb_pkg::DEPTH] = '{default: '0};
   logic [mrrb_pkg::WORD_W-1:0]     slot_seqno   [mrrb_pkg::DEPTH] = '{default: '0};
   logic [mrrb_pkg::WORD_W-1:0]     slot_tick    [mrrb_pkg::DEPTH] = '{default: '0};
   mrrb_pkg::mask_type              slot_pending [mrrb_pkg::DEPTH] = '{default: '0};
   mrrb_pkg::mask_type              slot_taken   [mrrb_pkg::DEPTH] = '{default: '0};
   mrrb_pkg::index_type             ring_head     = '0;
   mrrb_pkg::index_type             ring_tail     = '0;
   logic [mrrb_pkg::WORD_W-1:0]     tick_count    = '0;
   logic [mrrb_pkg::WORD_W-1:0]     drop_count    = '0;
   logic [mrrb_pkg::WORD_W-1:0]     last_seq      = '0;
   logic [mrrb_pkg::INTERVAL_W-1:0] tick_interval = mrrb_pkg::INTERVAL_RESET;

   mrrb_pkg::req_item_type req_backlog [$];
   mrrb_pkg::rsp_item_type rsp_awaited [$];
   mrrb_pkg::req_item_type drv_item;

   // occupancy as planned while the backlog is filled
   int                          plan_fill  = 0;
   mrrb_pkg::mask_type          plan_taken = '0;
   int                          enq_burst  = 0;
   logic [mrrb_pkg::WORD_W-1:0] seq_cursor = '0;

   bit steady = 1'b0;
   int send_gap;
   int recv_gap;
   int err_count = 0;
   int rsp_index = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("tb: errors");
      $finish;
   end

   // Applies one request to the ring and returns the response it produces.
   // DEPTH is a power of two, so index arithmetic wraps on its own.
   function automatic mrrb_pkg::rsp_item_type ring_predict(input mrrb_pkg::req_item_type q);
      mrrb_pkg::rsp_item_type r;
      mrrb_pkg::index_type    nxt;
      mrrb_pkg::index_type    t;
      mrrb_pkg::mask_type     rbit;
      mrrb_pkg::mask_type     need;
      r = '0;
      if (q.req_type == mrrb_pkg::REQ_ENQUEUE) begin
         nxt = ring_head + mrrb_pkg::index_type'(1);
         if (nxt == ring_tail) begin
            drop_count = drop_count + 32'd1;
            r.dropped = 1'b1;
         end else begin
            slot_pay[ring_head]   = q.payload;
            slot_seqno[ring_head] = q.seq_number;
            if (tick_interval != '0 && (q.seq_number % 32'(tick_interval)) == '0) begin
               tick_count = tick_count + 32'd1;
               slot_tick[ring_head] = tick_count;
            end else begin
               slot_tick[ring_head] = '0;
            end
            slot_pending[ring_head] = mrrb_pkg::ALL_MASK;
            slot_taken[ring_head]   = '0;
            ring_head = nxt;
         end
         last_seq = q.seq_number + 32'd1;
      end else begin
         t = ring_tail;
         if (q.reader <= mrrb_pkg::CHANNELS) begin
            rbit = mrrb_pkg::mask_type'(1) << q.reader;
            if ((slot_pending[t] & rbit) != '0) begin
               r.granted     = 1'b1;
               r.out_payload = slot_pay[t];
               r.out_seq     = slot_seqno[t];
               r.out_measure = slot_tick[t];
               slot_pending[t] = slot_pending[t] & ~rbit;
               slot_taken[t]   = slot_taken[t] | rbit;
            end
         end
         need = q.acq_active ? mrrb_pkg::ALL_MASK : mrrb_pkg::CHAN_MASK;
         if ((slot_taken[t] & need) == need) begin
            slot_pending[t] = '0;
            slot_taken[t]   = '0;
            if (slot_tick[t] != '0) begin
               r.telem_valid = 1'b1;
               r.telem_tick  = slot_tick[t];
               r.telem_seq   = last_seq;
               r.telem_head  = ring_head;
               r.telem_tail  = t;
               slot_tick[t]  = '0;
            end
            // the tail never steps onto the head slot
            if (t + mrrb_pkg::index_type'(1) != ring_head)
               ring_tail = t + mrrb_pkg::index_type'(1);
         end
      end
      r.overflow_count = drop_count;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [mrrb_pkg::WORD_W-1:0] pick_payload();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return '0;
      if (roll < 10)
         return '1;
      return $urandom;
   endfunction

   // mostly consecutive packet numbers, with jumps to ticks, to random values and to the top
   function automatic logic [mrrb_pkg::WORD_W-1:0] pick_seqno();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10 && tick_interval != '0)
         seq_cursor = $urandom_range(0, 4000000) * 32'(tick_interval);
      else if (roll < 15)
         seq_cursor = $urandom;
      else if (roll < 17)
         seq_cursor = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else
         seq_cursor = seq_cursor + 32'd1;
      return seq_cursor;
   endfunction

   function automatic mrrb_pkg::req_item_type make_enq(
         input logic [mrrb_pkg::WORD_W-1:0] pay,
         input logic [mrrb_pkg::WORD_W-1:0] seq);
      mrrb_pkg::req_item_type q;
      q.req_type   = mrrb_pkg::REQ_ENQUEUE;
      q.payload    = pay;
      q.seq_number = seq;
      q.reader     = mrrb_pkg::READER_W'($urandom_range(0, 15));
      q.acq_active = 1'($urandom_range(0, 1));
      return q;
   endfunction

   function automatic mrrb_pkg::req_item_type make_deq(input int rdr, input logic acq);
      mrrb_pkg::req_item_type q;
      q.req_type   = mrrb_pkg::REQ_DEQUEUE;
      q.payload    = $urandom;
      q.seq_number = $urandom;
      q.reader     = mrrb_pkg::READER_W'(rdr);
      q.acq_active = acq;
      return q;
   endfunction

   function automatic mrrb_pkg::req_item_type make_noise();
      mrrb_pkg::req_item_type q;
      q.req_type   = 1'($urandom_range(0, 1));
      q.payload    = $urandom;
      q.seq_number = $urandom;
      q.reader     = mrrb_pkg::READER_W'($urandom_range(0, 15));
      q.acq_active = 1'($urandom_range(0, 1));
      return q;
   endfunction

   // would this dequeue finish the planned tail slot
   function automatic bit plan_would_finish(input mrrb_pkg::req_item_type q);
      mrrb_pkg::mask_type seen;
      mrrb_pkg::mask_type need;
      seen = plan_taken;
      if (q.reader <= mrrb_pkg::CHANNELS)
         seen[q.reader] = 1'b1;
      need = q.acq_active ? mrrb_pkg::ALL_MASK : mrrb_pkg::CHAN_MASK;
      return (seen & need) == need;
   endfunction

   task automatic queue_req(input mrrb_pkg::req_item_type q);
      if (q.req_type == mrrb_pkg::REQ_ENQUEUE) begin
         if (plan_fill == 0)
            plan_taken = '0;
         if (plan_fill < mrrb_pkg::DEPTH - 1)
            plan_fill++;
      end else if (plan_fill > 0) begin
         if (plan_would_finish(q)) begin
            plan_taken = '0;
            if (plan_fill > 1)
               plan_fill--;
         end else if (q.reader <= mrrb_pkg::CHANNELS) begin
            plan_taken[q.reader] = 1'b1;
         end
      end
      req_backlog.push_back(q);
   endtask

   // Mostly readers taking the tail slot in random order, with enqueues
   // kept so that the last slot in the ring is never finished.
   task automatic queue_random(input int count);
      mrrb_pkg::req_item_type q;
      int                     cand [$];
      int                     enq_pct;
      repeat (count) begin
         enq_pct = (plan_fill < 3) ? 35 : ((plan_fill > 10) ? 3 : 9);
         if (enq_burst > 0) begin
            enq_burst--;
            q = make_enq(pick_payload(), pick_seqno());
         end else if ($urandom_range(0, 199) == 0) begin
            enq_burst = $urandom_range(14, 20);
            q = make_enq(pick_payload(), pick_seqno());
         end else if ($urandom_range(0, 99) < 5) begin
            q = make_noise();
         end else if (plan_fill == 0 || $urandom_range(0, 99) < enq_pct) begin
            q = make_enq(pick_payload(), pick_seqno());
         end else begin
            cand.delete();
            for (int r = 0; r <= mrrb_pkg::CHANNELS; r++)
               if (!plan_taken[r])
                  cand.push_back(r);
            q = make_deq(cand[$urandom_range(0, cand.size() - 1)],
                         1'($urandom_range(0, 1)));
         end
         if (q.req_type == mrrb_pkg::REQ_DEQUEUE && plan_fill == 1 && plan_would_finish(q))
            q = make_enq(pick_payload(), pick_seqno());
         queue_req(q);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_ch.valid || rsp_awaited.size() != 0);
   endtask

   task automatic set_interval(input int v);
      wait_drained();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= mrrb_pkg::INTERVAL_W'(v);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      tick_interval = mrrb_pkg::INTERVAL_W'(v);
   endtask

   task automatic note_error(input string what);
      err_count++;
      if (err_count <= 10)
         $display("[%0t] %s", $time, what);
   endtask

   function automatic string rsp_text(input mrrb_pkg::rsp_item_type r);
      return $sformatf({"gnt=%0d pay=%h seq=%h meas=%h drop=%0d tv=%0d tick=%h",
                        " tseq=%h th=%0d tt=%0d ovf=%h"},
                       r.granted, r.out_payload, r.out_seq, r.out_measure, r.dropped,
                       r.telem_valid, r.telem_tick, r.telem_seq, r.telem_head,
                       r.telem_tail, r.overflow_count);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.req_type   <= mrrb_pkg::REQ_ENQUEUE;
         req_ch.payload    <= '0;
         req_ch.seq_number <= '0;
         req_ch.reader     <= '0;
         req_ch.acq_active <= 1'b0;
         send_gap          <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            rsp_awaited.push_back(ring_predict(drv_item));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap     <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               drv_item = req_backlog.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.req_type   <= drv_item.req_type;
               req_ch.payload    <= drv_item.payload;
               req_ch.seq_number <= drv_item.seq_number;
               req_ch.reader     <= drv_item.reader;
               req_ch.acq_active <= drv_item.acq_active;
               send_gap          <= pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      mrrb_pkg::rsp_item_type got;
      mrrb_pkg::rsp_item_type want;
      int                     hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.granted        = rsp_ch.granted;
            got.out_payload    = rsp_ch.out_payload;
            got.out_seq        = rsp_ch.out_seq;
            got.out_measure    = rsp_ch.out_measure;
            got.dropped        = rsp_ch.dropped;
            got.telem_valid    = rsp_ch.telem_valid;
            got.telem_tick     = rsp_ch.telem_tick;
            got.telem_seq      = rsp_ch.telem_seq;
            got.telem_head     = rsp_ch.telem_head;
            got.telem_tail     = rsp_ch.telem_tail;
            got.overflow_count = rsp_ch.overflow_count;
            if (rsp_awaited.size() == 0) begin
               note_error($sformatf("unexpected result: %s", rsp_text(got)));
            end else begin
               want = rsp_awaited.pop_front();
               if (got !== want)
                  note_error($sformatf("result %0d mismatch\n  exp %s\n  got %s",
                                       rsp_index, rsp_text(want), rsp_text(got)));
            end
            rsp_index++;
            hold = pick_gap();
            recv_gap     <= hold;
            rsp_ch.ready <= (hold == 0);
         end else if (recv_gap > 0) begin
            recv_gap     <= recv_gap - 1;
            rsp_ch.ready <= (recv_gap == 1);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase_intervals [$];
      csr_write_en      <= 1'b0;
      csr_write_data    <= '0;
      reset             <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty ring, out-of-range reader, then one slot taken by everyone
      queue_req(make_deq(0, 1'b1));
      queue_req(make_deq(15, 1'b0));
      queue_req(make_enq(32'h0, 32'h0));
      queue_req(make_enq(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_req(make_enq(32'h5A5A_A5A5, 32'd200));
      queue_req(make_enq(32'h0000_1234, 32'd99));
      queue_req(make_deq(mrrb_pkg::CHANNELS, 1'b1));
      queue_req(make_deq(mrrb_pkg::CHANNELS + 1, 1'b1));
      for (int r = 0; r < mrrb_pkg::CHANNELS; r++) begin
         queue_req(make_deq(r, 1'b1));
         if (r == 5)
            queue_req(make_deq(r, 1'b1));
      end
      queue_req(make_deq(14, 1'b0));
      queue_random(200);

      phase_intervals = '{1, 1000, 0, 1023, 3, 50};
      phase_intervals.push_back($urandom_range(2, 999));
      foreach (phase_intervals[i]) begin
         set_interval(phase_intervals[i]);
         steady = ($urandom_range(0, 3) == 0);
         queue_random(170);
      end

      // drain to the last slot, finish it so the tail sticks, then overfill
      steady = 1'b0;
      while (plan_fill > 1) begin
         // every reader took the slot but the acquisition reader held it
         if ((plan_taken & mrrb_pkg::CHAN_MASK) == mrrb_pkg::CHAN_MASK)
            queue_req(make_deq(0, 1'b0));
         for (int r = 0; r < mrrb_pkg::CHANNELS; r++)
            if (plan_fill > 1 && !plan_taken[r])
               queue_req(make_deq(r, 1'b0));
      end
      if ((plan_taken & mrrb_pkg::CHAN_MASK) == mrrb_pkg::CHAN_MASK)
         queue_req(make_deq(0, 1'b0));
      for (int r = 0; r < mrrb_pkg::CHANNELS; r++)
         if (!plan_taken[r])
            queue_req(make_deq(r, 1'b0));
      repeat (mrrb_pkg::DEPTH + 1)
         queue_req(make_enq(pick_payload(), pick_seqno()));
      queue_req(make_deq(0, 1'b1));
      queue_req(make_deq(mrrb_pkg::CHANNELS, 1'b0));

      wait_drained();
      repeat (50) @(posedge clock);
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
